// ===== rtl/bgh_pkg.sv =====
package bgh_pkg;

  // Field and register widths of the block's ports.
  localparam int ACTION_W    = 2;
  localparam int GREY_W      = 8;
  localparam int ENTRY_W     = 9;
  localparam int COUNT_OUT_W = 20;
  localparam int REG_IDX_W   = 2;
  localparam int CFG_W       = 13;
  localparam int LINE_W      = 13;
  localparam int BSIZE_W     = 10;

  // Position counter widths.
  localparam int COL_LINE_W = 12;
  localparam int IN_BLOCK_W = 9;

  // Limits that the sizes are clamped to.
  localparam int LINE_MAX  = 4096;
  localparam int BLOCK_MAX = 512;

  // Register values after reset.
  localparam logic [LINE_W-1:0]  LINE_WIDTH_RESET   = 13'd128;
  localparam logic [BSIZE_W-1:0] BLOCK_WIDTH_RESET  = 10'd16;
  localparam logic [BSIZE_W-1:0] BLOCK_HEIGHT_RESET = 10'd16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD        = 2'd0,
    ACT_READ       = 2'd1,
    ACT_READ_CLEAR = 2'd2,
    ACT_RESTART    = 2'd3
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_BLOCK_WIDTH  = 2'd1,
    REG_BLOCK_HEIGHT = 2'd2
  } reg_index_t;

  // Decoded item handed from the position tracker to the count store.
  typedef struct packed {
    logic    take;
    action_t action;
    logic    hit;
  } ctl_t;

  // Status of the count store seen by the top level.
  typedef struct packed {
    logic clearing;
    logic busy;
  } stat_t;

endpackage

// ===== rtl/bgh_ifs.sv =====
interface bgh_req_if;
  import bgh_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [GREY_W-1:0]   grey;
  logic [ENTRY_W-1:0]  entry_index;

  modport source (output valid, output action, output grey, output entry_index,
                  input ready);
  modport sink (input valid, input action, input grey, input entry_index,
                output ready);
endinterface

interface bgh_rsp_if;
  import bgh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COUNT_OUT_W-1:0] count;

  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

// ===== rtl/block_grey_histogram.sv =====
// A result passes through the store's second stage and then the result queue
// before it is offered on rsp.
// Throughput: one item per cycle while req.ready stays high, set by the read-modify-write of
// the count memory with forwarding of the previous write.
// Reset: registers go to 128/16/16 and the count memory is zeroed by a pass over all
// BLOCKS_PER_SIDE*BLOCKS_PER_SIDE*BINS entries (512 by default) with req.ready low.
module block_grey_histogram #(
  parameter int BLOCKS_PER_SIDE = 8,
  parameter int BINS            = 8,
  parameter int COUNT_WIDTH     = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [bgh_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [bgh_pkg::CFG_W-1:0]     wr_data,
  bgh_req_if.sink                       req,
  bgh_rsp_if.source                     rsp
);
  import bgh_pkg::*;

  localparam int DEPTH  = BLOCKS_PER_SIDE * BLOCKS_PER_SIDE * BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  ctl_t                   ctl;
  stat_t                  stat;
  logic [ADDR_W-1:0]      addr;
  logic                   take;
  logic                   pop;
  logic [1:0]             level;
  logic                   res_valid;
  logic [COUNT_OUT_W-1:0] res_count;

  // Accept while the queue will have room for this item and the one in flight.
  assign pop       = rsp.valid && rsp.ready;
  assign req.ready = !stat.clearing
                     && ((3'(level) + 3'(stat.busy)) <= (3'd1 + 3'(pop)));
  assign take      = req.valid && req.ready;

  bgh_pos #(
    .BLOCKS_PER_SIDE(BLOCKS_PER_SIDE),
    .BINS           (BINS),
    .ADDR_W         (ADDR_W)
  ) u_pos (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .take       (take),
    .action     (req.action),
    .grey       (req.grey),
    .entry_index(req.entry_index),
    .ctl        (ctl),
    .addr       (addr)
  );

  bgh_store #(
    .DEPTH      (DEPTH),
    .ADDR_W     (ADDR_W),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .addr     (addr),
    .stat     (stat),
    .res_valid(res_valid),
    .res_count(res_count)
  );

  bgh_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_count(res_count),
    .level     (level),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/bgh_pos.sv =====
module bgh_pos #(
  parameter int BLOCKS_PER_SIDE = 8,
  parameter int BINS            = 8,
  parameter int ADDR_W          = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [bgh_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [bgh_pkg::CFG_W-1:0]     wr_data,
  input  logic                          take,
  input  logic [bgh_pkg::ACTION_W-1:0]  action,
  input  logic [bgh_pkg::GREY_W-1:0]    grey,
  input  logic [bgh_pkg::ENTRY_W-1:0]   entry_index,
  output bgh_pkg::ctl_t                 ctl,
  output logic [ADDR_W-1:0]             addr
);
  import bgh_pkg::*;

  localparam int DEPTH = BLOCKS_PER_SIDE * BLOCKS_PER_SIDE * BINS;
  localparam int BC_W  = $clog2(BLOCKS_PER_SIDE + 1);
  localparam int BIN_W = $clog2(BINS);
  localparam int PROD_W = GREY_W + 5;

  logic [LINE_W-1:0]     line_width;
  logic [BSIZE_W-1:0]    block_width;
  logic [BSIZE_W-1:0]    block_height;
  logic [COL_LINE_W-1:0] column_in_line;
  logic [IN_BLOCK_W-1:0] column_in_block;
  logic [IN_BLOCK_W-1:0] row_in_block;
  logic [BC_W-1:0]       block_column;
  logic [BC_W-1:0]       block_row;

  logic [LINE_W-1:0]  lw_eff;
  logic [BSIZE_W-1:0] bw_eff;
  logic [BSIZE_W-1:0] bh_eff;
  logic               line_end;
  logic               col_block_end;
  logic               row_block_end;
  logic               in_grid;
  logic [PROD_W-1:0]  bin_prod;
  logic [BIN_W-1:0]   bin;
  logic [ADDR_W-1:0]  pixel_addr;
  logic               entry_ok;
  action_t            act;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      block_width  <= BLOCK_WIDTH_RESET;
      block_height <= BLOCK_HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_LINE_WIDTH:   line_width   <= wr_data;
        REG_BLOCK_WIDTH:  block_width  <= wr_data[BSIZE_W-1:0];
        REG_BLOCK_HEIGHT: block_height <= wr_data[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping.
  always_comb begin
    if (line_width == '0) begin
      lw_eff = LINE_W'(1);
    end else if (line_width > LINE_W'(LINE_MAX)) begin
      lw_eff = LINE_W'(LINE_MAX);
    end else begin
      lw_eff = line_width;
    end
    bw_eff = (block_width > BSIZE_W'(BLOCK_MAX)) ? BSIZE_W'(BLOCK_MAX) : block_width;
    bh_eff = (block_height > BSIZE_W'(BLOCK_MAX)) ? BSIZE_W'(BLOCK_MAX) : block_height;
  end

  assign line_end      = (LINE_W'(column_in_line) + LINE_W'(1)) >= lw_eff;
  assign col_block_end = (BSIZE_W'(column_in_block) + BSIZE_W'(1)) >= bw_eff;
  assign row_block_end = (BSIZE_W'(row_in_block) + BSIZE_W'(1)) >= bh_eff;

  // Entry of the current pixel: block index times the bin count plus the bin.
  assign bin_prod   = PROD_W'(grey) * PROD_W'(BINS);
  assign bin        = bin_prod[GREY_W +: BIN_W];
  assign pixel_addr = (ADDR_W'(block_row) * ADDR_W'(BLOCKS_PER_SIDE) + ADDR_W'(block_column))
                      * ADDR_W'(BINS) + ADDR_W'(bin);
  assign in_grid    = (bw_eff != '0) && (bh_eff != '0)
                      && (block_column < BC_W'(BLOCKS_PER_SIDE))
                      && (block_row < BC_W'(BLOCKS_PER_SIDE));
  assign entry_ok   = {23'b0, entry_index} < 32'(DEPTH);
  assign act        = action_t'(action);

  // Decode the item for the store.
  always_comb begin
    ctl.take   = take;
    ctl.action = act;
    if (act == ACT_ADD) begin
      ctl.hit = in_grid;
      addr    = pixel_addr;
    end else begin
      ctl.hit = entry_ok;
      addr    = ADDR_W'(entry_index);
    end
  end

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_in_line  <= '0;
      column_in_block <= '0;
      block_column    <= '0;
      row_in_block    <= '0;
      block_row       <= '0;
    end else if (take && act == ACT_RESTART) begin
      column_in_line  <= '0;
      column_in_block <= '0;
      block_column    <= '0;
      row_in_block    <= '0;
      block_row       <= '0;
    end else if (take && act == ACT_ADD) begin
      if (line_end) begin
        column_in_line  <= '0;
        column_in_block <= '0;
        block_column    <= '0;
        if (bh_eff != '0) begin
          if (row_block_end) begin
            row_in_block <= '0;
            if (block_row < BC_W'(BLOCKS_PER_SIDE)) begin
              block_row <= block_row + BC_W'(1);
            end
          end else begin
            row_in_block <= row_in_block + IN_BLOCK_W'(1);
          end
        end
      end else begin
        column_in_line <= column_in_line + COL_LINE_W'(1);
        if (bw_eff != '0) begin
          if (col_block_end) begin
            column_in_block <= '0;
            if (block_column < BC_W'(BLOCKS_PER_SIDE)) begin
              block_column <= block_column + BC_W'(1);
            end
          end else begin
            column_in_block <= column_in_block + IN_BLOCK_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/bgh_store.sv =====
module bgh_store #(
  parameter int DEPTH       = 512,
  parameter int ADDR_W      = 9,
  parameter int COUNT_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bgh_pkg::ctl_t                   ctl,
  input  logic [ADDR_W-1:0]               addr,
  output bgh_pkg::stat_t                  stat,
  output logic                            res_valid,
  output logic [bgh_pkg::COUNT_OUT_W-1:0] res_count
);
  import bgh_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];

  logic                   clr_busy;
  logic [ADDR_W-1:0]      clr_addr;
  logic                   s1_valid;
  action_t                s1_action;
  logic                   s1_hit;
  logic [ADDR_W-1:0]      s1_addr;
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   fwd_hit;
  logic [COUNT_WIDTH-1:0] fwd_val;
  logic [COUNT_WIDTH-1:0] old_val;
  logic [COUNT_WIDTH-1:0] new_val;
  logic                   we;
  logic [31:0]            res_wide;

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Second stage: the item whose read data has just arrived.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= ctl.take;
      if (ctl.take) begin
        fwd_hit <= we && (s1_addr == addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      s1_action <= ctl.action;
      s1_hit    <= ctl.hit;
      s1_addr   <= addr;
      fwd_val   <= new_val;
    end
  end

  // The previous item's write lands on the same edge as this read, so take its value.
  assign old_val = fwd_hit ? fwd_val : rdata;

  // Modify: saturating increment or clear.
  always_comb begin
    new_val = old_val;
    we      = 1'b0;
    if (s1_valid && s1_hit) begin
      case (s1_action)
        ACT_ADD: begin
          we = 1'b1;
          if (old_val != COUNT_MAX) begin
            new_val = old_val + COUNT_WIDTH'(1);
          end
        end
        ACT_READ_CLEAR: begin
          we      = 1'b1;
          new_val = '0;
        end
        default: ;
      endcase
    end
  end

  // Count memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[s1_addr] <= new_val;
    end
    if (ctl.take) begin
      rdata <= mem[addr];
    end
  end

  // Result of the item in the second stage.
  always_comb begin
    res_wide = '0;
    if (s1_hit && (s1_action == ACT_READ || s1_action == ACT_READ_CLEAR)) begin
      res_wide = 32'(old_val);
    end
  end

  assign res_valid     = s1_valid;
  assign res_count     = res_wide[COUNT_OUT_W-1:0];
  assign stat.clearing = clr_busy;
  assign stat.busy     = s1_valid;

endmodule

// ===== rtl/bgh_outq.sv =====
module bgh_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [bgh_pkg::COUNT_OUT_W-1:0] push_count,
  output logic [1:0]                      level,
  bgh_rsp_if.source                       rsp
);
  import bgh_pkg::*;

  logic [COUNT_OUT_W-1:0] slots [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic                   pop;

  assign pop       = rsp.valid && rsp.ready;
  assign rsp.valid = (level != 2'd0);
  assign rsp.count = slots[rd_ptr];

  // Two-slot result queue; the top level never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      level <= level + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_count;
    end
  end

endmodule

// ===== rtl/bgh_checker.sv =====
module bgh_props (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [bgh_pkg::COUNT_OUT_W-1:0] rsp_count
);
  import bgh_pkg::*;

  // The clearing pass holds off items right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("item could be taken during the clearing pass");

  // A result offered to a stalled consumer holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
    else $error("result changed while stalled");

  // A result appearing at an empty output comes from a previously taken item.
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("result without a matching item");

endmodule

bind block_grey_histogram bgh_props u_bgh_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_count(rsp.count)
);
